// ===== src/pixel_replication_upscaler_top_macros.svh =====
// Assertion helpers used by the back end of the RTL.
`ifndef PIXEL_REPLICATION_UPSCALER_TOP_MACROS_SVH
`define PIXEL_REPLICATION_UPSCALER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UPR_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/upr_pkg.sv =====
`default_nettype none

package upr_pkg;

    localparam int MAX_ROW_PIXELS = 2048;
    localparam int COL_W          = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
    localparam int LCOL_W         = COL_W + 1;   // holds 0..MAX_ROW_PIXELS

    localparam int PIXEL_W  = 24;
    localparam int SCALE_W  = 7;
    localparam int SWIDTH_W = 12;
    localparam int SROWS_W  = 13;
    localparam int RCNT_W   = 12;   // rows_done, 0..ROWS_LIMIT-1
    localparam int ROWS_LIMIT = 4096;
    localparam int PAD_W    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ROWS  = 2'd2;

    localparam int QUEUE_DEPTH = 4;   // power of two
    localparam int Q_ADDR_W    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [PIXEL_W-1:0] pixel;
    } t_cmd;

    // Effective (saturated) configuration.
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [LCOL_W-1:0]  width;
        logic [SROWS_W-1:0] rows;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/upr_ram.sv =====
`default_nettype none

module upr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/upr_front.sv =====
`default_nettype none

module upr_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_action,
    input  wire logic [upr_pkg::PIXEL_W-1:0]  i_pixel_in,
    output logic                              o_cmd_valid,
    output upr_pkg::t_cmd                     o_cmd,
    input  wire logic                         i_cmd_pop
);

    upr_pkg::t_cmd                    r_mem [upr_pkg::QUEUE_DEPTH];
    logic [upr_pkg::Q_ADDR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [upr_pkg::Q_ADDR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [upr_pkg::Q_ADDR_W:0]       r_count,  n_count;
    upr_pkg::t_cmd                    cmd_in;
    logic                             push, pop;

    // classify the incoming transfer
    always_comb begin
        cmd_in.kind  = i_action ? upr_pkg::KIND_ADVANCE : upr_pkg::KIND_LOAD;
        cmd_in.pixel = i_pixel_in;
    end

    assign o_in_stall  = (r_count == (upr_pkg::Q_ADDR_W+1)'(upr_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== src/upr_back.sv =====
`default_nettype none
`include "pixel_replication_upscaler_top_macros.svh"

module upr_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  upr_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    input  upr_pkg::t_cfg                     i_cfg,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic [upr_pkg::PIXEL_W-1:0]       o_beat_value,
    output logic                              o_is_padding,
    output logic                              o_row_end,
    output logic                              o_image_end
);

    // sequencing state
    logic [upr_pkg::LCOL_W-1:0]  r_load_col,  n_load_col;
    logic                        r_emitting,  n_emitting;
    logic [upr_pkg::COL_W-1:0]   r_emit_col,  n_emit_col;
    logic [upr_pkg::SCALE_W-1:0] r_across,    n_across;
    logic [upr_pkg::SCALE_W-1:0] r_down,      n_down;
    logic [upr_pkg::PAD_W-1:0]   r_pad_left,  n_pad_left;
    logic [upr_pkg::RCNT_W-1:0]  r_rows_done, n_rows_done;

    // output register (pixel data sits in the RAM read register)
    logic r_out_valid;
    logic r_is_pad, r_row_end, r_img_end;
    logic n_is_pad, n_row_end, n_img_end;

    logic                        slot_free, beat_fire, finish;
    logic                        ram_we, ram_re;
    logic [upr_pkg::PIXEL_W-1:0] ram_rdata;
    logic [upr_pkg::LCOL_W-1:0]  load_inc, emit_inc;
    logic [upr_pkg::SCALE_W:0]   across_inc, down_inc;
    logic [upr_pkg::SROWS_W-1:0] rows_inc;
    logic [3:0]                  pad_prod;
    logic [upr_pkg::PAD_W-1:0]   pad;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign load_inc   = r_load_col + 1'b1;
    assign emit_inc   = {1'b0, r_emit_col} + 1'b1;
    assign across_inc = {1'b0, r_across} + 1'b1;
    assign down_inc   = {1'b0, r_down} + 1'b1;
    assign rows_inc   = {1'b0, r_rows_done} + 1'b1;
    // (width * scale) mod 4 needs only the low two bits of each
    assign pad_prod   = {2'b00, i_cfg.width[1:0]} * {2'b00, i_cfg.scale[1:0]};
    assign pad        = pad_prod[upr_pkg::PAD_W-1:0];

    always_comb begin
        n_load_col  = r_load_col;
        n_emitting  = r_emitting;
        n_emit_col  = r_emit_col;
        n_across    = r_across;
        n_down      = r_down;
        n_pad_left  = r_pad_left;
        n_rows_done = r_rows_done;
        n_is_pad    = 1'b0;
        n_row_end   = 1'b0;
        n_img_end   = 1'b0;
        o_cmd_pop   = 1'b0;
        beat_fire   = 1'b0;
        finish      = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (i_cmd_valid) begin
            if (i_cmd.kind == upr_pkg::KIND_LOAD) begin
                o_cmd_pop = 1'b1;
                if (!r_emitting) begin
                    ram_we     = (r_load_col < upr_pkg::LCOL_W'(upr_pkg::MAX_ROW_PIXELS));
                    n_load_col = load_inc;
                    if (load_inc >= i_cfg.width) begin
                        n_emitting = 1'b1;
                        n_emit_col = '0;
                        n_across   = '0;
                        n_pad_left = '0;
                    end
                end
            end else if (!r_emitting) begin
                o_cmd_pop = 1'b1;       // nothing to send: consumed silently
            end else if (slot_free) begin
                o_cmd_pop = 1'b1;
                beat_fire = 1'b1;
                if (r_pad_left != '0) begin
                    n_is_pad   = 1'b1;
                    n_pad_left = r_pad_left - 1'b1;
                    finish     = (r_pad_left == upr_pkg::PAD_W'(1));
                end else begin
                    ram_re = 1'b1;
                    if (across_inc >= {1'b0, i_cfg.scale}) begin
                        n_across = '0;
                        if (emit_inc >= i_cfg.width) begin
                            n_emit_col = '0;
                            if (pad != '0) begin
                                n_pad_left = pad;
                            end else begin
                                finish = 1'b1;
                            end
                        end else begin
                            n_emit_col = emit_inc[upr_pkg::COL_W-1:0];
                        end
                    end else begin
                        n_across = across_inc[upr_pkg::SCALE_W-1:0];
                    end
                end

                // end of an output row
                if (finish) begin
                    n_row_end = 1'b1;
                    if (down_inc >= {1'b0, i_cfg.scale}) begin
                        n_down     = '0;
                        n_emitting = 1'b0;
                        n_load_col = '0;
                        if (rows_inc >= i_cfg.rows) begin
                            n_rows_done = '0;
                            n_img_end   = 1'b1;
                        end else begin
                            n_rows_done = rows_inc[upr_pkg::RCNT_W-1:0];
                        end
                    end else begin
                        n_down = down_inc[upr_pkg::SCALE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col  <= '0;
            r_emitting  <= 1'b0;
            r_emit_col  <= '0;
            r_across    <= '0;
            r_down      <= '0;
            r_pad_left  <= '0;
            r_rows_done <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_load_col  <= n_load_col;
            r_emitting  <= n_emitting;
            r_emit_col  <= n_emit_col;
            r_across    <= n_across;
            r_down      <= n_down;
            r_pad_left  <= n_pad_left;
            r_rows_done <= n_rows_done;
            if (slot_free) begin
                r_out_valid <= beat_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_is_pad  <= n_is_pad;
            r_row_end <= n_row_end;
            r_img_end <= n_img_end;
        end
    end

    upr_ram #(
        .WIDTH (upr_pkg::PIXEL_W),
        .DEPTH (upr_pkg::MAX_ROW_PIXELS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_col[upr_pkg::COL_W-1:0]),
        .i_wdata (i_cmd.pixel),
        .i_re    (ram_re),
        .i_raddr (r_emit_col),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_beat_value = r_is_pad ? '0 : ram_rdata;
    assign o_is_padding = r_is_pad;
    assign o_row_end    = r_row_end;
    assign o_image_end  = r_img_end;

    `UPR_ASSERT_HOLDS(a_img_end_on_row_end, i_clk, i_rst_n, r_out_valid && r_img_end, r_row_end, "image end without row end")
    `UPR_ASSERT_HOLDS(a_no_pad_when_idle, i_clk, i_rst_n, !r_emitting, r_pad_left == '0, "padding pending while not emitting")
    `UPR_ASSERT_HOLDS(a_load_col_in_range, i_clk, i_rst_n, !r_emitting, r_load_col < upr_pkg::LCOL_W'(upr_pkg::MAX_ROW_PIXELS), "load column past row store")
    `UPR_ASSERT_NEXT(a_pixel_read_lands, i_clk, i_rst_n, beat_fire && ram_re, r_out_valid && !r_is_pad, "pixel beat lost")

endmodule

`default_nettype wire

// ===== src/pixel_replication_upscaler_top.sv =====
`default_nettype none
// Integer pixel-replication upscaler for 24-bit pixel rows.
// Input channel (i_in_valid / o_in_stall): action 0 loads one source pixel into
// the row store; after source_width loads the row is complete. Action 1 asks
// for one output beat: pixels repeated scale times across, then
// (width*scale) mod 4 zero padding beats; the row goes out scale times.
// Loads that arrive while a row is being sent are dropped; an advance with
// nothing to send is consumed without a transfer.
// Output channel (o_out_valid / i_out_stall): one beat per transfer with
// row_end and image_end marks.
// Config: write scale / source_width / source_rows via i_cfg_we, only while idle.
// An accepted advance passes the command queue, then the output register.
// Throughput: one item per cycle while the output is not stalled, set by the
// single row-store read port and the one back-end counter update per item.
// A 4-entry command queue sits between the front and back ends, so input
// transfers keep flowing while the output is stalled until the queue fills;
// a stalled beat holds its value.
// Reset (synchronous, active low) clears the queue, counters and registers to
// scale=1, width=1, rows=1; the row store is not cleared and needs no sweep.

module pixel_replication_upscaler_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config write port
    input  wire logic                           i_cfg_we,
    input  wire logic [upr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [upr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic [upr_pkg::PIXEL_W-1:0]    i_pixel_in,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [upr_pkg::PIXEL_W-1:0]         o_beat_value,
    output logic                                o_is_padding,
    output logic                                o_row_end,
    output logic                                o_image_end
);

    logic [upr_pkg::SCALE_W-1:0]  r_scale;
    logic [upr_pkg::SWIDTH_W-1:0] r_width;
    logic [upr_pkg::SROWS_W-1:0]  r_rows;
    upr_pkg::t_cfg                cfg;

    logic          cmd_valid, cmd_pop;
    upr_pkg::t_cmd cmd;

    // config registers; writes to unused indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= upr_pkg::SCALE_W'(1);
            r_width <= upr_pkg::SWIDTH_W'(1);
            r_rows  <= upr_pkg::SROWS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                upr_pkg::CFG_SCALE:        r_scale <= i_cfg_data[upr_pkg::SCALE_W-1:0];
                upr_pkg::CFG_SOURCE_WIDTH: r_width <= i_cfg_data[upr_pkg::SWIDTH_W-1:0];
                upr_pkg::CFG_SOURCE_ROWS:  r_rows  <= i_cfg_data[upr_pkg::SROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate config to legal ranges (zero reads as one)
    always_comb begin
        cfg.scale = (r_scale == '0) ? upr_pkg::SCALE_W'(1) : r_scale;

        if (r_width == '0) begin
            cfg.width = upr_pkg::LCOL_W'(1);
        end else if (int'(r_width) > upr_pkg::MAX_ROW_PIXELS) begin
            cfg.width = upr_pkg::LCOL_W'(upr_pkg::MAX_ROW_PIXELS);
        end else begin
            cfg.width = upr_pkg::LCOL_W'(r_width);
        end

        if (r_rows == '0) begin
            cfg.rows = upr_pkg::SROWS_W'(1);
        end else if (int'(r_rows) > upr_pkg::ROWS_LIMIT) begin
            cfg.rows = upr_pkg::SROWS_W'(upr_pkg::ROWS_LIMIT);
        end else begin
            cfg.rows = r_rows;
        end
    end

    // front end: accept and classify, queue commands
    upr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_pixel_in  (i_pixel_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back end: row store, replication counters, output register
    upr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .i_cfg        (cfg),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_beat_value (o_beat_value),
        .o_is_padding (o_is_padding),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end)
    );

endmodule

`default_nettype wire

// ===== tb/upscaler_checker.sv =====
// Watches both channels and the register port, predicts each output beat from
// the accepted input transfers and compares in order.
module upscaler_checker
    import upr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_action,
    input  logic [PIXEL_W-1:0]    i_pixel_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [PIXEL_W-1:0]    i_beat_value,
    input  logic                  i_is_padding,
    input  logic                  i_row_end,
    input  logic                  i_image_end,
    output int                    o_fail_count,
    output int                    o_beats_pending,
    output int                    o_beats_checked,
    output int                    o_pad_beats,
    output int                    o_row_ends,
    output int                    o_image_ends
);

    localparam int ROW_ALIGN = 4;   // pad beats per output row are (w * s) mod this

    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic               pad;
        logic               row_end;
        logic               image_end;
    } beat_t;

    beat_t expected_beats[$];

    // register copies
    logic [SCALE_W-1:0]  scale_reg;
    logic [SWIDTH_W-1:0] width_reg;
    logic [SROWS_W-1:0]  rows_reg;

    // sequencer state
    logic [PIXEL_W-1:0] row_pixels [MAX_ROW_PIXELS];
    int unsigned        fill_col;
    bit                 sending;
    int unsigned        send_col;
    int unsigned        across_cnt;
    int unsigned        down_cnt;
    int unsigned        pad_left;
    int unsigned        rows_done;

    function automatic int unsigned eff_scale();
        return (scale_reg == 0) ? 1 : scale_reg;
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
        return width_reg;
    endfunction

    function automatic int unsigned eff_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > ROWS_LIMIT) return ROWS_LIMIT;
        return rows_reg;
    endfunction

    // last beat of an output row; returns the image-end mark
    function automatic logic close_output_row();
        down_cnt++;
        if (down_cnt >= eff_scale()) begin
            down_cnt  = 0;
            sending   = 1'b0;
            fill_col  = 0;
            rows_done++;
            if (rows_done >= eff_rows()) begin
                rows_done = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic predict_item(input logic act, input logic [PIXEL_W-1:0] pix);
        int unsigned w;
        int unsigned s;
        beat_t       b;
        w = eff_width();
        s = eff_scale();
        b = '0;
        if (t_kind'(act) == KIND_LOAD) begin
            if (!sending) begin   // loads during a row send are dropped
                if (fill_col < MAX_ROW_PIXELS) row_pixels[fill_col] = pix;
                fill_col++;
                if (fill_col >= w) begin
                    sending    = 1'b1;
                    send_col   = 0;
                    across_cnt = 0;
                    pad_left   = 0;
                end
            end
        end else if (sending) begin
            if (pad_left > 0) begin
                b.pad = 1'b1;
                pad_left--;
                if (pad_left == 0) begin
                    b.row_end   = 1'b1;
                    b.image_end = close_output_row();
                end
            end else begin
                b.value = row_pixels[send_col];
                across_cnt++;
                if (across_cnt >= s) begin
                    across_cnt = 0;
                    if (send_col + 1 >= w) begin
                        send_col = 0;
                        if ((w * s) % ROW_ALIGN != 0) begin
                            pad_left = (w * s) % ROW_ALIGN;
                        end else begin
                            b.row_end   = 1'b1;
                            b.image_end = close_output_row();
                        end
                    end else begin
                        send_col++;
                    end
                end
            end
            expected_beats.push_back(b);
        end
    endtask

    task automatic check_beat();
        beat_t want;
        if (expected_beats.size() == 0) begin
            $error("unexpected beat: value %06h pad %0b row_end %0b image_end %0b",
                   i_beat_value, i_is_padding, i_row_end, i_image_end);
            o_fail_count++;
        end else begin
            want = expected_beats.pop_front();
            if (i_beat_value !== want.value) begin
                $error("beat_value: expected %06h, got %06h", want.value, i_beat_value);
                o_fail_count++;
            end
            if (i_is_padding !== want.pad) begin
                $error("is_padding: expected %0b, got %0b", want.pad, i_is_padding);
                o_fail_count++;
            end
            if (i_row_end !== want.row_end) begin
                $error("row_end: expected %0b, got %0b", want.row_end, i_row_end);
                o_fail_count++;
            end
            if (i_image_end !== want.image_end) begin
                $error("image_end: expected %0b, got %0b", want.image_end, i_image_end);
                o_fail_count++;
            end
            o_beats_checked++;
            if (want.pad) o_pad_beats++;
            if (want.row_end) o_row_ends++;
            if (want.image_end) o_image_ends++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_beats.delete();
            scale_reg       = 1;
            width_reg       = 1;
            rows_reg        = 1;
            fill_col        = 0;
            sending         = 1'b0;
            send_col        = 0;
            across_cnt      = 0;
            down_cnt        = 0;
            pad_left        = 0;
            rows_done       = 0;
            o_fail_count    = 0;
            o_beats_checked = 0;
            o_pad_beats     = 0;
            o_row_ends      = 0;
            o_image_ends    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCALE:        scale_reg = i_cfg_data[SCALE_W-1:0];
                    CFG_SOURCE_WIDTH: width_reg = i_cfg_data[SWIDTH_W-1:0];
                    CFG_SOURCE_ROWS:  rows_reg  = i_cfg_data[SROWS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_item(i_action, i_pixel_in);
            if (i_out_valid && !i_out_stall) check_beat();
        end
        o_beats_pending = expected_beats.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the upscaler. The checker beside the block does all
// prediction and comparison; this module only drives transfers and registers.
module tb_top;
    import upr_pkg::*;

    localparam int RANDOM_ITEMS  = 1300;
    localparam int CYCLE_LIMIT   = 400_000;    // several times the slowest legal run
    localparam int HOLD_CYCLES   = 400;        // long output hold-off
    localparam int SETTLE_CYCLES = 8;          // command queue depth plus the output register path
    localparam int END_CYCLES    = 20;
    localparam int ROW_ALIGN     = 4;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SCALE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_action    = KIND_LOAD;
    logic [PIXEL_W-1:0]    i_pixel_in  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PIXEL_W-1:0]    o_beat_value;
    logic                  o_is_padding;
    logic                  o_row_end;
    logic                  o_image_end;

    int fail_count;
    int beats_pending;
    int beats_checked;
    int pad_beats;
    int row_ends;
    int image_ends;

    // knobs set by the stimulus; the receiver process reads the stall ones
    bit send_gaps_on   = 1'b0;
    bit recv_stalls_on = 1'b0;
    bit hold_request   = 1'b0;

    int in_transfers  = 0;
    int useful_items  = 0;   // items that load a pixel or produce a beat
    int settings_used = 0;
    int long_holds    = 0;
    int cycle_count   = 0;

    pixel_replication_upscaler_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_beat_value (o_beat_value),
        .o_is_padding (o_is_padding),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end)
    );

    upscaler_checker beat_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_pixel_in      (i_pixel_in),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_beat_value    (o_beat_value),
        .i_is_padding    (o_is_padding),
        .i_row_end       (o_row_end),
        .i_image_end     (o_image_end),
        .o_fail_count    (fail_count),
        .o_beats_pending (beats_pending),
        .o_beats_checked (beats_checked),
        .o_pad_beats     (pad_beats),
        .o_row_ends      (row_ends),
        .o_image_ends    (image_ends)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hang anywhere (stuck stall, lost beat) ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, beats_pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output side. Stall comes in random bursts while enabled; a hold request
    // from the stimulus freezes the output long enough for the internal queue
    // to fill and push back on the input channel.
    initial begin : receiver
        int burst;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                long_holds++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (recv_stalls_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 16);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Mostly random pixels, with all-zeros and all-ones mixed in often.
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return r[PIXEL_W-1:0];
        endcase
    endfunction

    // One input transfer. Called at a rising edge; returns at the edge where the
    // transfer happened. Valid stays high between back-to-back items and is only
    // dropped for an idle burst, so it is never lowered and raised in one step.
    task automatic send_item(input t_kind kind, input logic [PIXEL_W-1:0] pix);
        int gap;
        if (send_gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= kind;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (o_in_stall);
        in_transfers++;
    endtask

    // Let the block go quiet: every predicted beat has come out and the
    // trailing no-result items have cleared the queue.
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (beats_pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes all three registers on consecutive edges; only called when idle.
    task automatic write_config(input int scale_val, input int width_val,
                                input int rows_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCALE;
        i_cfg_data  <= scale_val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_SOURCE_WIDTH;
        i_cfg_data  <= width_val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_SOURCE_ROWS;
        i_cfg_data  <= rows_val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // One source row: w loads, then exactly the advances that send the row out
    // s times with its padding. With noise on, ignored advances go into the load
    // part and dropped loads into the send part; neither shifts the row framing.
    task automatic feed_row(input int w, input int s, input bit noisy);
        int beats;
        beats = s * (w * s + (w * s) % ROW_ALIGN);
        for (int c = 0; c < w; c++) begin
            if (noisy && $urandom_range(0, 9) == 0) send_item(KIND_ADVANCE, pick_pixel());
            send_item(KIND_LOAD, pick_pixel());
        end
        for (int b = 0; b < beats; b++) begin
            if (noisy && $urandom_range(0, 9) == 0) send_item(KIND_LOAD, pick_pixel());
            send_item(KIND_ADVANCE, pick_pixel());
        end
        useful_items += w + beats;
    endtask

    // Quiesce, program a setting, then push num_rows full source rows through.
    // Register values outside the legal range saturate inside the block.
    task automatic run_phase(input int scale_val, input int width_val, input int rows_val,
                             input int num_rows, input bit noisy);
        int s;
        int w;
        drain(SETTLE_CYCLES);
        write_config(scale_val, width_val, rows_val);
        s = (scale_val == 0) ? 1 : scale_val;
        w = (width_val == 0) ? 1 :
            ((width_val > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : width_val);
        repeat (num_rows) feed_row(w, s, noisy);
    endtask

    initial begin : stimulus
        int mode;
        int s;
        int w;
        int r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset setting (scale 1, width 1, rows 1) ----
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        send_item(KIND_ADVANCE, 24'h123456);   // nothing to send: no beat
        send_item(KIND_LOAD, 24'h000000);      // completes the one-pixel row
        send_item(KIND_LOAD, 24'hFFFFFF);      // arrives mid-send: dropped
        send_item(KIND_ADVANCE, 24'hFFFFFF);   // pixel beat
        send_item(KIND_ADVANCE, 24'h000000);   // one padding beat, ends the image
        send_item(KIND_ADVANCE, 24'h000000);   // idle again: no beat
        send_item(KIND_ADVANCE, 24'h000000);
        send_item(KIND_ADVANCE, 24'hABCDEF);

        // 3 wide, scale 2: 6 pixel beats + 2 pad per row, row sent twice;
        // image not done yet since two source rows are configured
        run_phase(2, 3, 2, 0, 1'b0);
        send_item(KIND_LOAD, 24'hFFFFFF);
        send_item(KIND_LOAD, 24'h000000);
        send_item(KIND_LOAD, 24'h800001);
        repeat (16) send_item(KIND_ADVANCE, pick_pixel());

        // zero in every register behaves as one; rows count carried over
        run_phase(0, 0, 0, 1, 1'b0);

        // ---- long output hold while the input keeps offering ----
        drain(SETTLE_CYCLES);
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        run_phase(4, 8, 3, 0, 1'b0);
        hold_request = 1'b1;
        feed_row(8, 4, 1'b0);

        // ---- register extremes, kept cheap in the other dimensions ----
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        run_phase(13, 1, 1, 1, 1'b1);                  // large scale, one pixel
        run_phase(1, 160, 8191, 1, 1'b1);              // wider row, rows saturate
        run_phase(3, 1, ROWS_LIMIT, 4, 1'b1);          // three pad beats per row

        // ---- random settings and rows; final stretch without idling ----
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            mode = (useful_items > RANDOM_ITEMS * 9 / 10) ? 0 : $urandom_range(0, 3);
            send_gaps_on   = mode[0];
            recv_stalls_on = mode[1];
            if ($urandom_range(0, 9) == 0) begin
                s = $urandom_range(6, 10);
                w = $urandom_range(1, 4);
            end else begin
                s = $urandom_range(1, 5);
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
            end
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4);
            run_phase(s, w, r, $urandom_range(1, 3), 1'b1);
        end

        drain(END_CYCLES);

        $display("Run covered %0d input transfers under %0d register settings", in_transfers,
                 settings_used);
        $display("%0d beats checked: %0d padding, %0d row ends, %0d image ends, %0d long holds",
                 beats_checked, pad_beats, row_ends, image_ends, long_holds);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
